/* rtl/utf8_utf16_transcoder_unit_macros.svh */
// Assertion macros for the UTF-8 / UTF-16 transcoder.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef UTF8_UTF16_TRANSCODER_UNIT_MACROS_SVH
`define UTF8_UTF16_TRANSCODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define UTT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define UTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/utt_pkg.sv */
// Shared types, constants and code unit helpers of the transcoder.
// No dependencies; every other RTL file but the macro header imports this package.
`default_nettype none

package utt_pkg;

	localparam int unsigned UNIT_W = 16;
	localparam int unsigned OCTET_W = 8;
	localparam int unsigned CP_W = 21;
	localparam int unsigned BUF_N = 4;
	localparam int unsigned HELD_N = 3;

	localparam logic [CP_W-1:0] CP_LIMIT = 21'h110000;
	localparam logic [CP_W-1:0] SURR_BASE = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_END = 21'h00E000;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
	localparam logic [CP_W-1:0] CP_2BYTE = 21'h000080;
	localparam logic [CP_W-1:0] CP_3BYTE = 21'h000800;

	localparam logic [UNIT_W-1:0] HI_SURR16 = 16'hD800;
	localparam logic [UNIT_W-1:0] LO_SURR16 = 16'hDC00;
	localparam logic [UNIT_W-1:0] END_SURR16 = 16'hE000;
	localparam logic [UNIT_W-1:0] TEN_MASK = 16'h03FF;

	localparam logic [OCTET_W-1:0] CONT_MASK = 8'hC0;
	localparam logic [OCTET_W-1:0] CONT_TAG = 8'h80;
	localparam logic [OCTET_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [OCTET_W-1:0] LEAD2_TAG = 8'hC0;
	localparam logic [OCTET_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [OCTET_W-1:0] LEAD3_TAG = 8'hE0;
	localparam logic [OCTET_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [OCTET_W-1:0] LEAD4_TAG = 8'hF0;
	localparam logic [OCTET_W-1:0] SIX_MASK = 8'h3F;
	localparam logic [OCTET_W-1:0] FIVE_MASK = 8'h1F;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		ACT_SKIP,
		ACT_EMIT,
		ACT_DONE
	} act_t;

	typedef enum logic {
		DIR_8TO16 = 1'b0,
		DIR_16TO8 = 1'b1
	} dir_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic emit;
	} cmd_t;

	typedef struct packed {
		dir_t dir;
		logic can_push;
		act_t act;
		logic scan_fin;
		logic pair;
		logic load_emits;
		logic emit_last;
		logic emit_fin;
	} stat_t;

	// Sequence length from a lead byte; zero for a continuation or bad lead.
	function automatic logic [2:0] lead_len(input logic [OCTET_W-1:0] b);
		logic [2:0] r;
		if (!b[7])
			r = 3'd1;
		else if ((b & CONT_MASK) == CONT_TAG)
			r = 3'd0;
		else if ((b & LEAD2_MASK) == LEAD2_TAG)
			r = 3'd2;
		else if ((b & LEAD3_MASK) == LEAD3_TAG)
			r = 3'd3;
		else if ((b & LEAD4_MASK) == LEAD4_TAG)
			r = 3'd4;
		else
			r = 3'd0;
		return r;
	endfunction

	function automatic logic [2:0] unit_count(input logic [CP_W-1:0] cp, input dir_t dir);
		logic [2:0] r;
		if (dir == DIR_8TO16)
			r = (cp < SUPP_BASE) ? 3'd1 : 3'd2;
		else if (cp < CP_2BYTE)
			r = 3'd1;
		else if (cp < CP_3BYTE)
			r = 3'd2;
		else if (cp < SUPP_BASE)
			r = 3'd3;
		else
			r = 3'd4;
		return r;
	endfunction

	// Destination unit number idx of code point cp.
	function automatic logic [UNIT_W-1:0] unit_at(input logic [CP_W-1:0] cp, input dir_t dir,
			input logic [1:0] idx);
		logic [CP_W-1:0] v;
		logic [OCTET_W-1:0] octet;
		logic [UNIT_W-1:0] r;
		v = cp - SUPP_BASE;
		octet = '0;
		if (dir == DIR_8TO16) begin
			if (cp < SUPP_BASE)
				r = cp[UNIT_W-1:0];
			else if (idx == 2'd0)
				r = HI_SURR16 + {6'b0, v[19:10]};
			else
				r = LO_SURR16 + {6'b0, v[9:0]};
		end else begin
			case (unit_count(cp, DIR_16TO8))
				3'd1: octet = cp[7:0];
				3'd2: begin
					if (idx == 2'd0)
						octet = LEAD2_TAG | ({3'b0, cp[10:6]} & FIVE_MASK);
					else
						octet = CONT_TAG | {2'b0, cp[5:0]};
				end
				3'd3: begin
					case (idx)
						2'd0: octet = LEAD3_TAG | {4'b0, cp[15:12]};
						2'd1: octet = CONT_TAG | {2'b0, cp[11:6]};
						default: octet = CONT_TAG | {2'b0, cp[5:0]};
					endcase
				end
				default: begin
					case (idx)
						2'd0: octet = LEAD4_TAG | {5'b0, cp[20:18]};
						2'd1: octet = CONT_TAG | {2'b0, cp[17:12]};
						2'd2: octet = CONT_TAG | {2'b0, cp[11:6]};
						default: octet = CONT_TAG | ({2'b0, cp[5:0]} & SIX_MASK);
					endcase
				end
			endcase
			r = {8'h00, octet};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/utt_if.sv */
// Channel interfaces of the transcoder: source units, result units, register write.
// Depends on utt_pkg for widths.
`default_nettype none

interface utt_in_if import utt_pkg::*; ;
	logic valid;
	logic ready;
	logic [UNIT_W-1:0] code_unit;
	logic string_end;
	modport source (output valid, code_unit, string_end, input ready);
	modport sink (input valid, code_unit, string_end, output ready);
endinterface

interface utt_out_if import utt_pkg::*; ;
	logic valid;
	logic ready;
	logic [UNIT_W-1:0] out_unit;
	logic run_last;
	modport source (output valid, out_unit, run_last, input ready);
	modport sink (input valid, out_unit, run_last, output ready);
endinterface

interface utt_cfg_if;
	logic valid;
	logic ready;
	logic direction;
	modport source (output valid, direction, input ready);
	modport sink (input valid, direction, output ready);
endinterface

`default_nettype wire

/* rtl/utt_ctrl.sv */
// Sequencer of the transcoder: accepts a unit, steps the byte scan, emits units.
// Depends on utt_pkg; drives the datapath through cmd_t and reads stat_t.
`default_nettype none

module utt_ctrl import utt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  src_valid,
	output logic  src_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t st_q;
	state_t st_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_nxt;
	end

	always_comb begin
		st_nxt = st_q;
		cmd = '0;
		src_ready = 1'b0;
		case (st_q)
			ST_IDLE: begin
				src_ready = 1'b1;
				if (src_valid) begin
					cmd.load = 1'b1;
					if (stat.dir == DIR_8TO16)
						st_nxt = ST_SCAN;
					else if (stat.load_emits)
						st_nxt = ST_EMIT;
				end
			end
			ST_SCAN: begin
				case (stat.act)
					ACT_EMIT: begin
						// hold until the result stage has room
						if (stat.can_push) begin
							cmd.scan = 1'b1;
							if (stat.pair)
								st_nxt = ST_EMIT;
							else if (stat.scan_fin)
								st_nxt = ST_IDLE;
						end
					end
					ACT_SKIP: begin
						cmd.scan = 1'b1;
						if (stat.scan_fin)
							st_nxt = ST_IDLE;
					end
					ACT_DONE: begin
						cmd.scan = 1'b1;
						st_nxt = ST_IDLE;
					end
					default: st_nxt = ST_IDLE;
				endcase
			end
			ST_EMIT: begin
				if (stat.can_push) begin
					cmd.emit = 1'b1;
					if (stat.emit_last)
						st_nxt = stat.emit_fin ? ST_IDLE : ST_SCAN;
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/utt_datapath.sv */
// Datapath of the transcoder: byte buffer and scan decode, surrogate pairing,
// held units, code point register, pending and output unit registers. Uses utt_pkg.
`default_nettype none

module utt_datapath import utt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [UNIT_W-1:0] in_unit,
	input  logic              in_end,
	input  logic              cfg_we,
	input  logic              cfg_dir,
	input  cmd_t              cmd,
	output stat_t             stat,
	output logic              dst_valid,
	output logic [UNIT_W-1:0] dst_unit,
	output logic              dst_last,
	input  logic              dst_ready
);

	dir_t dir_q;
	logic [1:0] hc_q;
	logic [UNIT_W-1:0] held_q [HELD_N];
	logic [OCTET_W-1:0] buf_q [BUF_N];
	logic [2:0] n_q;
	logic [2:0] i_q;
	logic end_q;
	logic [CP_W-1:0] cp_q;
	logic [2:0] nb_q;
	logic [1:0] idx_q;
	logic [2:0] k_q;
	logic pend_v_q;
	logic pend_last_q;
	logic [UNIT_W-1:0] pend_unit_q;
	logic out_v_q;
	logic out_last_q;
	logic [UNIT_W-1:0] out_unit_q;

	// byte scan
	logic [OCTET_W-1:0] win [BUF_N];
	logic [2:0] avail;
	logic [2:0] len;
	logic [2:0] step;
	logic [2:0] i_next;
	act_t act;
	logic hold;
	logic found;
	logic cp_ok;
	logic [CP_W-1:0] cp_scan;
	logic scan_fin;
	logic pair;

	always_comb begin
		for (int j = 0; j < BUF_N; j++)
			win[j] = buf_q[2'(i_q + 3'(j))];
		avail = n_q - i_q;
		len = lead_len(win[0]);
		case (len)
			3'd2: cp_scan = {10'b0, win[0][4:0], win[1][5:0]};
			3'd3: cp_scan = {5'b0, win[0][3:0], win[1][5:0], win[2][5:0]};
			3'd4: cp_scan = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
			default: cp_scan = {13'b0, win[0]};
		endcase
		found = 1'b0;
		step = 3'd1;
		for (int j = 1; j < BUF_N; j++) begin
			if (3'(j) < len && !found) begin
				if (win[j] == '0) begin
					found = 1'b1;
					step = 3'(j + 1);
				end else if ((win[j] & CONT_MASK) != CONT_TAG) begin
					found = 1'b1;
					step = 3'(j);
				end
			end
		end
		cp_ok = (cp_scan < CP_LIMIT) && !(cp_scan >= SURR_BASE && cp_scan < SURR_END);
		act = ACT_SKIP;
		hold = 1'b0;
		if (i_q >= n_q) begin
			act = ACT_DONE;
		end else if (win[0] == '0 || len == 3'd0) begin
			step = 3'd1;
		end else if (len == 3'd1) begin
			act = ACT_EMIT;
			step = 3'd1;
		end else if (avail < len) begin
			// incomplete: keep it unless the string ends here
			act = ACT_DONE;
			hold = !end_q;
		end else if (!found) begin
			step = len;
			act = cp_ok ? ACT_EMIT : ACT_SKIP;
		end
		i_next = i_q + step;
		scan_fin = (act == ACT_DONE) || (i_next >= n_q);
		pair = (act == ACT_EMIT) && (unit_count(cp_scan, DIR_8TO16) == 3'd2);
	end

	// UTF-16 unit against the held high surrogate
	logic u_lo;
	logic u_surr;
	logic h_hi;
	logic emits16;
	logic hold16;
	logic [CP_W-1:0] cp16;
	logic [2:0] nb16;

	always_comb begin
		u_lo = (in_unit >= LO_SURR16) && (in_unit < END_SURR16);
		u_surr = (in_unit >= HI_SURR16) && (in_unit < END_SURR16);
		h_hi = (hc_q != 2'd0) && (held_q[0] >= HI_SURR16) && (held_q[0] < LO_SURR16);
		emits16 = 1'b0;
		hold16 = 1'b0;
		cp16 = {5'b0, in_unit};
		if (h_hi && u_lo) begin
			emits16 = 1'b1;
			cp16 = {1'b0, held_q[0][9:0] & TEN_MASK[9:0], in_unit[9:0]} + SUPP_BASE;
		end else if (in_unit == '0) begin
			emits16 = 1'b0;
		end else if (!u_surr) begin
			emits16 = 1'b1;
		end else if (!(in_unit >= LO_SURR16 || in_end)) begin
			hold16 = 1'b1;
		end
		nb16 = emits16 ? unit_count(cp16, DIR_16TO8) : 3'd0;
	end

	// unit production into the pending register
	logic emit_last;
	logic emit_fin;
	logic out_free;
	logic can_push;
	logic prod;
	logic prod_fin;
	logic fin_only;
	logic [UNIT_W-1:0] prod_unit;
	logic push;
	logic mark;
	logic move;

	always_comb begin
		emit_last = ({1'b0, idx_q} == nb_q - 3'd1);
		emit_fin = (dir_q == DIR_16TO8) || (i_q >= n_q);
		out_free = !out_v_q || dst_ready;
		can_push = !pend_v_q || out_free;
		prod = 1'b0;
		prod_fin = 1'b0;
		fin_only = 1'b0;
		prod_unit = '0;
		if (cmd.scan) begin
			case (act)
				ACT_EMIT: begin
					prod = 1'b1;
					prod_unit = unit_at(cp_scan, DIR_8TO16, 2'd0);
					prod_fin = scan_fin && !pair;
				end
				ACT_SKIP: fin_only = scan_fin;
				ACT_DONE: fin_only = 1'b1;
				default: fin_only = 1'b0;
			endcase
		end
		if (cmd.emit) begin
			prod = 1'b1;
			prod_unit = unit_at(cp_q, dir_q, idx_q);
			prod_fin = emit_last && emit_fin;
		end
		// at most four units per transaction
		push = prod && !k_q[2];
		mark = fin_only || (prod && !push && prod_fin);
		move = pend_v_q && out_free && (push || pend_last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_8TO16;
			hc_q <= '0;
			n_q <= '0;
			i_q <= '0;
			nb_q <= '0;
			idx_q <= '0;
			k_q <= '0;
			pend_v_q <= 1'b0;
			pend_last_q <= 1'b0;
			out_v_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dir_q <= dir_t'(cfg_dir);
				hc_q <= '0;
			end
			if (cmd.load) begin
				k_q <= '0;
				if (dir_q == DIR_8TO16) begin
					n_q <= {1'b0, hc_q} + 3'd1;
					i_q <= '0;
					hc_q <= '0;
				end else begin
					hc_q <= hold16 ? 2'd1 : 2'd0;
					nb_q <= nb16;
					idx_q <= '0;
				end
			end
			if (cmd.scan) begin
				i_q <= i_next;
				if (act == ACT_DONE && hold)
					hc_q <= avail[1:0];
				if (pair) begin
					nb_q <= 3'd2;
					idx_q <= 2'd1;
				end
			end
			if (cmd.emit)
				idx_q <= idx_q + 2'd1;
			if (push)
				k_q <= k_q + 3'd1;
			if (push) begin
				pend_v_q <= 1'b1;
				pend_last_q <= prod_fin;
			end else if (move) begin
				pend_v_q <= 1'b0;
			end else if (mark) begin
				pend_last_q <= 1'b1;
			end
			if (move) begin
				out_v_q <= 1'b1;
				out_last_q <= pend_last_q;
			end else if (dst_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && dir_q == DIR_8TO16) begin
			for (int j = 0; j < HELD_N; j++)
				buf_q[j] <= (2'(j) < hc_q) ? held_q[j][7:0] : in_unit[7:0];
			buf_q[BUF_N-1] <= in_unit[7:0];
			end_q <= in_end;
		end
		if (cmd.load && dir_q == DIR_16TO8) begin
			cp_q <= cp16;
			if (hold16)
				held_q[0] <= in_unit;
		end
		if (cmd.scan && act == ACT_DONE && hold) begin
			for (int j = 0; j < HELD_N; j++)
				held_q[j] <= {8'h00, win[j]};
		end
		if (cmd.scan && pair)
			cp_q <= cp_scan;
		if (push)
			pend_unit_q <= prod_unit;
		if (move)
			out_unit_q <= pend_unit_q;
	end

	always_comb begin
		stat.dir = dir_q;
		stat.can_push = can_push;
		stat.act = act;
		stat.scan_fin = scan_fin;
		stat.pair = pair;
		stat.load_emits = emits16;
		stat.emit_last = emit_last;
		stat.emit_fin = emit_fin;
	end

	assign dst_valid = out_v_q;
	assign dst_unit = out_unit_q;
	assign dst_last = out_last_q;

endmodule

`default_nettype wire

/* rtl/utf8_utf16_transcoder_unit.sv */
// channel  role  payload                    accepted when
// src      sink  code_unit[15:0] string_end src.valid && src.ready
// dst      src   out_unit[15:0]  run_last   dst.valid && dst.ready
// cfg      sink  direction                  cfg.valid && cfg.ready (always ready)
//
// UTF-8 to UTF-16: the byte is taken while idle, then one scan step per sequence
// or dropped byte of the held-plus-new buffer; a low surrogate gets an emit step.
// UTF-16 to UTF-8: the unit is taken while idle, then one emit step per byte.
// The result sequencer shares one pending and one output register; when dst
// stalls with both full, emitting and scans that emit hold. No clearing pass after reset.
// Top level: joins utt_ctrl and utt_datapath; uses utt_pkg, utt_if and the macros.
`default_nettype none

`include "utf8_utf16_transcoder_unit_macros.svh"

module utf8_utf16_transcoder_unit import utt_pkg::*; (
	input logic clk,
	input logic arst_n,
	utt_in_if.sink src,
	utt_out_if.source dst,
	utt_cfg_if.sink cfg
);

	cmd_t cmd;
	stat_t stat;
	logic src_ready;
	logic [2:0] cmd_bits;

	assign cfg.ready = 1'b1;
	assign src.ready = src_ready;
	assign cmd_bits = cmd;

	utt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src.valid),
		.src_ready (src_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	utt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_unit   (src.code_unit),
		.in_end    (src.string_end),
		.cfg_we    (cfg.valid),
		.cfg_dir   (cfg.direction),
		.cmd       (cmd),
		.stat      (stat),
		.dst_valid (dst.valid),
		.dst_unit  (dst.out_unit),
		.dst_last  (dst.run_last),
		.dst_ready (dst.ready)
	);

	`UTT_ASSERT_NOW(a_cmd_single, 1'b1, $onehot0(cmd_bits), "more than one datapath command")
	`UTT_ASSERT_NEXT(a_utf8_busy, src.valid && src_ready && stat.dir == DIR_8TO16, !src_ready, "UTF-8 transaction did not enter the scan")
	`UTT_ASSERT_NOW(a_emit_room, cmd.emit, stat.can_push, "unit emitted with no room in the result stage")

endmodule

`default_nettype wire

/* tb/sv/utt_checker.sv */
// Transaction checker for the UTF-8 / UTF-16 transcoder: predicts result units, compares in order.
// Watches the src, dst and cfg channels of utt_if; takes widths and dir_t from utt_pkg.
module utt_checker import utt_pkg::*; (
	input logic clk,
	input logic arst_n,
	utt_in_if src,
	utt_out_if dst,
	utt_cfg_if cfg,
	output int fails,
	output int pending
);

	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic last;
	} dst_item_t;

	dst_item_t pending_units[$];
	logic [UNIT_W-1:0] held_units [HELD_N];
	int held_cnt;
	dir_t dir;
	logic [UNIT_W-1:0] step_units [4];
	int step_n;

	task automatic report_mismatch(input string what, input logic [UNIT_W-1:0] got,
			input logic [UNIT_W-1:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
		fails++;
	endtask

	function automatic void put_unit(input logic [UNIT_W-1:0] v);
		if (step_n < 4) begin
			step_units[step_n] = v;
			step_n++;
		end
	endfunction

	function automatic void put_utf16(input logic [CP_W-1:0] cp);
		logic [CP_W-1:0] v;
		if (cp < 21'h10000) begin
			put_unit(cp[15:0]);
		end else begin
			v = cp - 21'h10000;
			put_unit({6'b110110, v[19:10]});
			put_unit({6'b110111, v[9:0]});
		end
	endfunction

	function automatic void put_utf8(input logic [CP_W-1:0] cp);
		if (cp < 21'h80) begin
			put_unit({9'h000, cp[6:0]});
		end else if (cp < 21'h800) begin
			put_unit({8'h00, 3'b110, cp[10:6]});
			put_unit({8'h00, 2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			put_unit({8'h00, 4'b1110, cp[15:12]});
			put_unit({8'h00, 2'b10, cp[11:6]});
			put_unit({8'h00, 2'b10, cp[5:0]});
		end else begin
			put_unit({8'h00, 5'b11110, cp[20:18]});
			put_unit({8'h00, 2'b10, cp[17:12]});
			put_unit({8'h00, 2'b10, cp[11:6]});
			put_unit({8'h00, 2'b10, cp[5:0]});
		end
	endfunction

	function automatic int seq_length(input logic [7:0] b);
		casez (b)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default: return 0;
		endcase
	endfunction

	// Decode held bytes plus the new one; replay what follows a broken sequence.
	function automatic void decode_utf8(input logic [UNIT_W-1:0] u, input logic fin);
		logic [7:0] bytes [4];
		logic [7:0] b;
		logic [7:0] c;
		logic [CP_W-1:0] cp;
		int n;
		int i;
		int j;
		int len;
		int skip;
		n = 0;
		i = 0;
		for (j = 0; j < held_cnt; j++) begin
			bytes[n] = held_units[j][7:0];
			n++;
		end
		bytes[n] = u[7:0];
		n++;
		held_cnt = 0;
		while (i < n) begin
			b = bytes[i];
			len = seq_length(b);
			if (b == 8'h00 || len == 0) begin
				i++;
				continue;
			end
			if (len == 1) begin
				put_utf16({13'b0, b});
				i++;
				continue;
			end
			if (n - i < len) begin
				// hold the incomplete tail unless the string ends here
				if (!fin) begin
					for (j = 0; i + j < n; j++)
						held_units[j] = {8'h00, bytes[i + j]};
					held_cnt = n - i;
				end
				break;
			end
			case (len)
				2: cp = {16'b0, b[4:0]};
				3: cp = {17'b0, b[3:0]};
				default: cp = {18'b0, b[2:0]};
			endcase
			skip = 0;
			for (j = 1; j < len; j++) begin
				c = bytes[i + j];
				if (c == 8'h00) begin
					skip = j + 1;
					break;
				end
				if (c[7:6] != 2'b10) begin
					skip = j;
					break;
				end
				cp = {cp[14:0], c[5:0]};
			end
			if (skip > 0) begin
				i += skip;
				continue;
			end
			if (cp < 21'h110000 && !(cp >= 21'hD800 && cp < 21'hE000))
				put_utf16(cp);
			i += len;
		end
	endfunction

	function automatic void decode_utf16(input logic [UNIT_W-1:0] u, input logic fin);
		logic [UNIT_W-1:0] hi;
		if (held_cnt > 0) begin
			hi = held_units[0];
			held_cnt = 0;
			if (u >= 16'hDC00 && u < 16'hE000 && hi >= 16'hD800 && hi < 16'hDC00) begin
				put_utf8({1'b0, hi[9:0], u[9:0]} + 21'h10000);
				return;
			end
		end
		if (u == 16'h0000)
			return;
		if (u < 16'hD800 || u >= 16'hE000) begin
			put_utf8({5'b0, u});
			return;
		end
		if (u >= 16'hDC00 || fin)
			return;
		held_units[0] = u;
		held_cnt = 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dst_item_t want;
		dst_item_t item;
		int k;
		if (!arst_n) begin
			pending_units.delete();
			held_cnt = 0;
			dir = DIR_8TO16;
			fails = 0;
			pending = 0;
		end else begin
			// compare results before queueing this edge's input
			if (dst.valid && dst.ready) begin
				if (pending_units.size() == 0) begin
					report_mismatch("unexpected result", dst.out_unit, '0);
				end else begin
					want = pending_units.pop_front();
					if (dst.out_unit !== want.unit)
						report_mismatch("out_unit", dst.out_unit, want.unit);
					if (dst.run_last !== want.last)
						report_mismatch("run_last", {15'b0, dst.run_last}, {15'b0, want.last});
				end
			end
			if (cfg.valid && cfg.ready) begin
				dir = dir_t'(cfg.direction);
				held_cnt = 0;
			end
			if (src.valid && src.ready) begin
				step_n = 0;
				if (dir == DIR_16TO8)
					decode_utf16(src.code_unit, src.string_end);
				else
					decode_utf8(src.code_unit, src.string_end);
				for (k = 0; k < step_n; k++) begin
					item.unit = step_units[k];
					item.last = (k == step_n - 1);
					pending_units.push_back(item);
				end
			end
			pending = pending_units.size();
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for utf8_utf16_transcoder_unit: clock, reset, source and register stimulus,
// result-side backpressure and the verdict. Depends on utt_pkg, utt_if and utt_checker.
module tb_top;
	import utt_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic fin;
	} src_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fails;
	int pending;
	int quiet_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	src_item_t plan[$];

	utt_in_if src_ch();
	utt_out_if dst_ch();
	utt_cfg_if cfg_ch();

	utf8_utf16_transcoder_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.src(src_ch),
		.dst(dst_ch),
		.cfg(cfg_ch)
	);

	utt_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.src(src_ch),
		.dst(dst_ch),
		.cfg(cfg_ch),
		.fails(fails),
		.pending(pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if ((src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[utf8_utf16_transcoder_unit] ERROR");
			$finish;
		end
	end

	function automatic void add(input logic [UNIT_W-1:0] unit, input logic fin);
		src_item_t it;
		it.unit = unit;
		it.fin = fin;
		plan.push_back(it);
	endfunction

	// UTF-8 byte with junk in the ignored upper half
	function automatic void add_byte(input logic [7:0] b);
		logic [7:0] hi;
		hi = 8'($urandom_range(0, 255));
		add({hi, b}, 1'b0);
	endfunction

	function automatic void end_string();
		src_item_t it;
		if (plan.size() > 0) begin
			it = plan[plan.size() - 1];
			it.fin = 1'b1;
			plan[plan.size() - 1] = it;
		end
	endfunction

	// Encode with a chosen length, so overlong and out-of-range forms are possible
	function automatic void add_utf8_char(input logic [CP_W-1:0] cp, input int len);
		case (len)
			1: add_byte({1'b0, cp[6:0]});
			2: begin
				add_byte({3'b110, cp[10:6]});
				add_byte({2'b10, cp[5:0]});
			end
			3: begin
				add_byte({4'b1110, cp[15:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
			default: begin
				add_byte({5'b11110, cp[20:18]});
				add_byte({2'b10, cp[17:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic logic [CP_W-1:0] cp_for_len(input int len);
		case (len)
			1: return CP_W'($urandom_range(1, 'h7F));
			2: return CP_W'($urandom_range('h80, 'h7FF));
			3: return CP_W'($urandom_range('h800, 'hFFFF));
			default: return CP_W'($urandom_range('h10000, 'h10FFFF));
		endcase
	endfunction

	function automatic logic [UNIT_W-1:0] bmp_unit();
		case ($urandom_range(0, 3))
			0: return UNIT_W'($urandom_range(1, 'h7F));
			1: return UNIT_W'($urandom_range('h80, 'h7FF));
			2: return UNIT_W'($urandom_range('h800, 'hD7FF));
			default: return UNIT_W'($urandom_range('hE000, 'hFFFF));
		endcase
	endfunction

	function automatic void plan_utf8(input int count);
		int start;
		int pick;
		int len;
		int idx;
		src_item_t it;
		start = plan.size();
		while (plan.size() - start < count) begin
			pick = $urandom_range(0, 99);
			len = $urandom_range(1, 4);
			if (pick < 58) begin
				add_utf8_char(cp_for_len(len), len);
			end else if (pick < 64) begin
				add_utf8_char(CP_W'($urandom_range(0, 'h7F)), $urandom_range(2, 4));
			end else if (pick < 70) begin
				add_utf8_char(CP_W'($urandom_range('h110000, 'h1FFFFF)), 4);
			end else if (pick < 75) begin
				add_utf8_char(CP_W'($urandom_range('hD800, 'hDFFF)), 3);
			end else if (pick < 83) begin
				// cut the tail off; the next lead breaks it unless the string ends
				len = $urandom_range(2, 4);
				add_utf8_char(cp_for_len(len), len);
				repeat ($urandom_range(1, len - 1))
					void'(plan.pop_back());
				if ($urandom_range(0, 1) == 0)
					end_string();
			end else if (pick < 88) begin
				len = $urandom_range(2, 4);
				add_utf8_char(cp_for_len(len), len);
				idx = plan.size() - $urandom_range(1, len - 1);
				it = plan[idx];
				it.unit[7:0] = 8'h00;
				plan[idx] = it;
			end else if (pick < 94) begin
				add(UNIT_W'($urandom_range(0, 'hFFFF)), 1'b0);
			end else begin
				add_byte(8'h80 | 8'($urandom_range(0, 'h3F)));
			end
			if ($urandom_range(0, 5) == 0)
				end_string();
		end
	endfunction

	function automatic void plan_utf16(input int count);
		int start;
		int pick;
		start = plan.size();
		while (plan.size() - start < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				add(bmp_unit(), 1'b0);
			end else if (pick < 74) begin
				add(UNIT_W'($urandom_range('hD800, 'hDBFF)), 1'b0);
				add(UNIT_W'($urandom_range('hDC00, 'hDFFF)), 1'b0);
			end else if (pick < 79) begin
				add(UNIT_W'($urandom_range('hDC00, 'hDFFF)), 1'b0);
			end else if (pick < 84) begin
				add(UNIT_W'($urandom_range('hD800, 'hDBFF)), 1'b0);
				add(bmp_unit(), 1'b0);
			end else if (pick < 88) begin
				add(UNIT_W'($urandom_range('hD800, 'hDBFF)), 1'b1);
			end else if (pick < 91) begin
				add(UNIT_W'($urandom_range('hD800, 'hDBFF)), 1'b0);
				add(UNIT_W'($urandom_range('hD800, 'hDBFF)), 1'b0);
			end else if (pick < 94) begin
				add(16'h0000, 1'b0);
			end else begin
				add(UNIT_W'($urandom_range(0, 'hFFFF)), 1'b0);
			end
			if ($urandom_range(0, 5) == 0)
				end_string();
		end
	endfunction

	// Leaves valid high after the last transaction; the caller drops it
	task automatic send_plan();
		int gap;
		foreach (plan[i]) begin
			gap = 0;
			if (!no_idle && $urandom_range(0, 5) == 0)
				gap = $urandom_range(1, 18);
			if (gap > 0) begin
				src_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			src_ch.valid <= 1'b1;
			src_ch.code_unit <= plan[i].unit;
			src_ch.string_end <= plan[i].fin;
			do @(posedge clk); while (!src_ch.ready);
		end
		plan.delete();
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_direction(input dir_t d);
		wait_drained();
		// let a held sequence settle inside the block before the write
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.direction <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int stall_left;
		int run_left;
		int hold_left;
		stall_left = 0;
		run_left = 0;
		hold_left = 0;
		dst_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				dst_ch.ready <= 1'b0;
				hold_left--;
			end else if (no_idle) begin
				dst_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				dst_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				dst_ch.ready <= 1'b1;
				if (run_left > 0) begin
					run_left--;
				end else begin
					run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
						: $urandom_range(0, 12);
					stall_left = $urandom_range(1, 18);
				end
			end
		end
	end

	initial begin
		src_ch.valid = 1'b0;
		src_ch.code_unit = '0;
		src_ch.string_end = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.direction = DIR_8TO16;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_direction(DIR_8TO16);

		add(16'h0000, 1'b0);
		add_byte(8'h7F);
		end_string();
		add_utf8_char(21'hA9, 2);
		add_utf8_char(21'h10FFFF, 4);
		add_byte(8'h80);
		add(16'hFFFF, 1'b0);
		add_utf8_char(21'h110000, 4);
		add_utf8_char(21'hD800, 3);
		add_utf8_char(21'h41, 2);
		add_byte(8'hC2);
		add_byte(8'h00);
		add_byte(8'h41);
		end_string();
		add_byte(8'hC2);
		add_byte(8'h41);
		add_byte(8'hE2);
		add_byte(8'h82);
		end_string();
		// half a sequence, then a write that abandons it
		add_byte(8'hE2);
		add_byte(8'h82);
		send_plan();
		src_ch.valid <= 1'b0;
		write_direction(DIR_8TO16);
		add(16'h00AC, 1'b1);
		send_plan();
		src_ch.valid <= 1'b0;

		write_direction(DIR_16TO8);
		add(16'h0000, 1'b0);
		add(16'h0041, 1'b1);
		add(16'h0080, 1'b0);
		add(16'h07FF, 1'b0);
		add(16'h0800, 1'b0);
		add(16'hFFFF, 1'b1);
		add(16'hE000, 1'b0);
		add(16'hD800, 1'b0);
		add(16'hDC00, 1'b0);
		add(16'hDBFF, 1'b0);
		add(16'hDFFF, 1'b1);
		add(16'hDC00, 1'b0);
		add(16'hD800, 1'b0);
		add(16'h0041, 1'b0);
		add(16'hD800, 1'b1);
		add(16'hDBFF, 1'b0);
		add(16'hDBFE, 1'b0);
		add(16'hDC01, 1'b1);
		add(16'hD800, 1'b0);
		send_plan();
		src_ch.valid <= 1'b0;
		write_direction(DIR_16TO8);
		add(16'hDC00, 1'b1);
		plan_utf16(100);
		send_plan();
		src_ch.valid <= 1'b0;

		write_direction(DIR_8TO16);
		// starve the result side so the block backs up into its input
		hold_req = 1'b1;
		plan_utf8(80);
		send_plan();
		src_ch.valid <= 1'b0;
		wait_drained();
		plan_utf8(60);
		send_plan();
		src_ch.valid <= 1'b0;

		write_direction(DIR_16TO8);
		plan_utf16(40);
		send_plan();
		src_ch.valid <= 1'b0;

		write_direction(DIR_8TO16);
		no_idle = 1'b1;
		plan_utf8(50);
		send_plan();
		src_ch.valid <= 1'b0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("[utf8_utf16_transcoder_unit] OK");
		else
			$display("[utf8_utf16_transcoder_unit] ERROR");
		$finish;
	end

endmodule
